>>> rtl/blrc_pkg.sv
// shared types and constants of the ray leaf collector
`timescale 1ns / 1ps

package blrc_pkg;

  localparam int NodeCount      = 1024;
  localparam int NodeW          = $clog2(NodeCount);
  localparam int BndDepth       = NodeCount * 6;
  localparam int BndAw          = $clog2(BndDepth);
  localparam int StackDepth     = 64;
  localparam int StackAw        = $clog2(StackDepth);
  localparam int DepthW         = $clog2(StackDepth + 1);
  localparam int MaxLeafResults = 64;
  localparam int RecW           = $clog2(MaxLeafResults + 1);
  localparam int TestW          = $clog2(NodeCount + 1);
  localparam int TWidth         = 51;

  localparam logic signed [TWidth-1:0] TNegOne  = -51'sd65536;
  localparam logic [23:0]              TotalMax = 24'hFFFFFF;

  localparam logic       ReqWrite  = 1'b0;
  localparam logic       ReqQuery  = 1'b1;
  localparam logic [2:0] WordCount = 3'd6;
  localparam logic [2:0] WordLink  = 3'd7;

  typedef struct packed {
    logic               req_type;
    logic [9:0]         node_index;
    logic [2:0]         word_select;
    logic signed [31:0] word_value;
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
  } blrc_req_t;

  typedef struct packed {
    logic [15:0] hit_first_prim;
    logic [15:0] hit_count;
    logic [23:0] total_prims;
    logic        last_hit;
    logic        overflow;
  } blrc_res_t;

endpackage

>>> rtl/bvh_ray_leaf_collector_unit.sv
// top level of the ray leaf collector: node table, reciprocal, slab test and walk sequencer
`timescale 1ns / 1ps

//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------------------
//  request  | start_i, busy_o, req_i         | word taken when start_i && !busy_o
//  result   | res_valid_o, res_o             | one-cycle strobe, receiver cannot stall
//
//  a node write leaves busy_o low
//  a ray query first forms three reciprocals, one per axis, on a bit-serial divider
//  each tested node then goes through a walk step, six bound reads through the
//  shared 17x33 multiplier in two partial products, a near/far update per axis and the
//  decide step; a leaf or push step, a pop or a revisit follows, and the closing word ends it
//  busy_o stays high throughout a query
//  reset clears control only; the node table and stack hold garbage until written

module bvh_ray_leaf_collector_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  blrc_pkg::blrc_req_t req_i,
  output logic                res_valid_o,
  output blrc_pkg::blrc_res_t res_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StRecip  = 4'd1;
  localparam logic [3:0] StWalk   = 4'd2;
  localparam logic [3:0] StBrd    = 4'd3;
  localparam logic [3:0] StBdiff  = 4'd4;
  localparam logic [3:0] StMulLo  = 4'd5;
  localparam logic [3:0] StMulHi  = 4'd6;
  localparam logic [3:0] StSign   = 4'd7;
  localparam logic [3:0] StMm     = 4'd8;
  localparam logic [3:0] StNf     = 4'd9;
  localparam logic [3:0] StDecide = 4'd10;
  localparam logic [3:0] StLeaf   = 4'd11;
  localparam logic [3:0] StPop    = 4'd12;
  localparam logic [3:0] StPopRd  = 4'd13;
  localparam logic [3:0] StFinish = 4'd14;

  localparam int TW = blrc_pkg::TWidth;
  localparam int NW = blrc_pkg::NodeW;

  // storage
  logic [31:0]         bnd_mem [blrc_pkg::BndDepth];
  logic [15:0]         cnt_mem [blrc_pkg::NodeCount];
  logic [15:0]         link_mem[blrc_pkg::NodeCount];
  logic [NW+1:0]       stk_mem [blrc_pkg::StackDepth];

  logic [31:0]         bnd_rd_q;
  logic [15:0]         cnt_rd_q, link_rd_q;
  logic [NW+1:0]       stk_rd_q;

  logic [3:0]          state_q;
  logic signed [31:0]  org_q [3];
  logic                dneg_q [3];
  logic [31:0]         dmag_q [3];
  logic [32:0]         inv_q [3];
  logic [1:0]          axis_q;
  logic                hi_q;
  logic [32:0]         rem_q, quo_q;
  logic [5:0]          dcnt_q;

  logic [NW-1:0]       cur_node_q;
  logic [1:0]          cur_child_q;
  logic [blrc_pkg::DepthW-1:0] depth_q;
  logic [blrc_pkg::TestW-1:0]  tests_q;
  logic [blrc_pkg::RecW-1:0]   nrec_q;
  logic                ovf_q;

  logic [32:0]         mag_q;
  logic                neg_q;
  logic [49:0]         acc_q;
  logic [65:0]         prod_q;
  logic signed [TW-1:0] t_q, mn_q, mx_q, near_q, far_q;
  logic signed [TW-1:0] t0_q [3];

  logic                pend_valid_q;
  blrc_pkg::blrc_res_t pend_q;
  logic                res_valid_q;
  blrc_pkg::blrc_res_t res_q;

  logic                accept;
  assign accept = start_i && (state_q == StIdle);

  // node table writes and registered reads
  logic [blrc_pkg::BndAw-1:0] wr_baddr, rd_baddr;
  logic [1:0]                 bsel;
  assign wr_baddr = (blrc_pkg::BndAw'(req_i.node_index) << 2)
                  + (blrc_pkg::BndAw'(req_i.node_index) << 1)
                  + blrc_pkg::BndAw'(req_i.word_select);
  assign bsel     = hi_q ? 2'd3 : 2'd0;
  assign rd_baddr = (blrc_pkg::BndAw'(cur_node_q) << 2)
                  + (blrc_pkg::BndAw'(cur_node_q) << 1)
                  + blrc_pkg::BndAw'(bsel) + blrc_pkg::BndAw'(axis_q);

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == blrc_pkg::ReqWrite &&
        req_i.word_select != blrc_pkg::WordCount && req_i.word_select != blrc_pkg::WordLink) begin
      bnd_mem[wr_baddr] <= req_i.word_value;
    end
    bnd_rd_q <= bnd_mem[rd_baddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == blrc_pkg::ReqWrite &&
        req_i.word_select == blrc_pkg::WordCount) begin
      cnt_mem[req_i.node_index] <= req_i.word_value[15:0];
    end
    cnt_rd_q <= cnt_mem[cur_node_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == blrc_pkg::ReqWrite &&
        req_i.word_select == blrc_pkg::WordLink) begin
      link_mem[req_i.node_index] <= req_i.word_value[15:0];
    end
    link_rd_q <= link_mem[cur_node_q];
  end

  // walk stack below the top entry; top lives in cur_node_q / cur_child_q
  logic [blrc_pkg::DepthW-1:0] depth_m1, depth_m2;
  logic [1:0]                  child_inc;
  assign depth_m1  = depth_q - blrc_pkg::DepthW'(1);
  assign depth_m2  = depth_q - blrc_pkg::DepthW'(2);
  assign child_inc = cur_child_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (state_q == StLeaf && cnt_rd_q == 16'd0 &&
        depth_q < blrc_pkg::DepthW'(blrc_pkg::StackDepth)) begin
      stk_mem[depth_m1[blrc_pkg::StackAw-1:0]] <= {cur_node_q, child_inc};
    end
    if (state_q == StPop) begin
      stk_rd_q <= stk_mem[depth_m2[blrc_pkg::StackAw-1:0]];
    end
  end

  // bit-serial reciprocal step: 2^32 / |d|
  logic [32:0] rem_sh;
  logic        qbit;
  logic [32:0] quo_nx;
  assign rem_sh = {rem_q[31:0], (dcnt_q == 6'd0)};
  assign qbit   = (rem_sh >= {1'b0, dmag_q[axis_q]});
  assign quo_nx = {quo_q[31:0], qbit};

  // shared multiplier: 17 bits of the distance times the reciprocal magnitude
  logic [16:0] mul_a;
  logic [49:0] mul_out;
  assign mul_a   = (state_q == StMulLo) ? mag_q[16:0] : {1'b0, mag_q[32:17]};
  assign mul_out = 50'(mul_a) * 50'(inv_q[axis_q]);

  logic signed [32:0] diff;
  assign diff = {bnd_rd_q[31], bnd_rd_q} - {org_q[axis_q][31], org_q[axis_q]};

  logic [49:0] pmag;
  assign pmag = prod_q[65:16];

  logic [24:0] total_sum;
  assign total_sum = {1'b0, pend_q.total_prims} + 25'(cnt_rd_q);

  logic [NW-1:0] child_node;
  assign child_node = (cur_child_q != 2'd0) ? link_rd_q[NW-1:0] : cur_node_q + NW'(1);

  always_ff @(posedge clk_i) begin
    case (state_q)
      StBdiff: begin
        mag_q <= diff[32] ? 33'(-diff) : 33'(diff);
        neg_q <= diff[32] ^ dneg_q[axis_q];
      end
      StMulLo: acc_q  <= mul_out;
      StMulHi: prod_q <= {16'd0, acc_q} + {mul_out[48:0], 17'd0};
      StSign:  t_q    <= neg_q ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
      StMm: begin
        if (!hi_q) begin
          t0_q[axis_q] <= t_q;
        end else begin
          mn_q <= (t0_q[axis_q] < t_q) ? t0_q[axis_q] : t_q;
          mx_q <= (t0_q[axis_q] < t_q) ? t_q : t0_q[axis_q];
        end
      end
      StNf: begin
        near_q <= (axis_q == 2'd0 || mn_q > near_q) ? mn_q : near_q;
        far_q  <= (axis_q == 2'd0 || mx_q < far_q) ? mx_q : far_q;
      end
      default: begin
      end
    endcase
    if (accept) begin
      org_q[0]  <= req_i.ray_origin_x;
      org_q[1]  <= req_i.ray_origin_y;
      org_q[2]  <= req_i.ray_origin_z;
      dneg_q[0] <= req_i.ray_dir_x[31];
      dneg_q[1] <= req_i.ray_dir_y[31];
      dneg_q[2] <= req_i.ray_dir_z[31];
      dmag_q[0] <= req_i.ray_dir_x[31] ? 32'(-req_i.ray_dir_x) : req_i.ray_dir_x;
      dmag_q[1] <= req_i.ray_dir_y[31] ? 32'(-req_i.ray_dir_y) : req_i.ray_dir_y;
      dmag_q[2] <= req_i.ray_dir_z[31] ? 32'(-req_i.ray_dir_z) : req_i.ray_dir_z;
    end
    if (state_q == StRecip && dcnt_q == 6'd32) begin
      inv_q[axis_q] <= (dmag_q[axis_q] == 32'd0) ? 33'h1_0000_0000 : quo_nx;
    end
  end

  // walk sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      axis_q       <= 2'd0;
      hi_q         <= 1'b0;
      rem_q        <= '0;
      quo_q        <= '0;
      dcnt_q       <= '0;
      cur_node_q   <= '0;
      cur_child_q  <= '0;
      depth_q      <= '0;
      tests_q      <= '0;
      nrec_q       <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept && req_i.req_type == blrc_pkg::ReqQuery) begin
            state_q <= StRecip;
            axis_q  <= 2'd0;
            rem_q   <= '0;
            quo_q   <= '0;
            dcnt_q  <= '0;
          end
        end
        StRecip: begin
          if (dcnt_q == 6'd32) begin
            rem_q  <= '0;
            quo_q  <= '0;
            dcnt_q <= '0;
            if (axis_q == 2'd2) begin
              // root on the stack, fresh query counters
              axis_q       <= 2'd0;
              state_q      <= StWalk;
              depth_q      <= blrc_pkg::DepthW'(1);
              cur_node_q   <= '0;
              cur_child_q  <= 2'd0;
              tests_q      <= '0;
              nrec_q       <= '0;
              ovf_q        <= 1'b0;
              pend_valid_q <= 1'b0;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end else begin
            rem_q  <= qbit ? rem_sh - {1'b0, dmag_q[axis_q]} : rem_sh;
            quo_q  <= quo_nx;
            dcnt_q <= dcnt_q + 6'd1;
          end
        end
        StWalk: begin
          if (depth_q == '0) begin
            state_q <= StFinish;
          end else if (cur_child_q[1]) begin
            state_q <= StPop;
          end else if (cur_child_q == 2'd0) begin
            if (tests_q >= blrc_pkg::TestW'(blrc_pkg::NodeCount)) begin
              ovf_q   <= 1'b1;
              state_q <= StFinish;
            end else begin
              tests_q <= tests_q + blrc_pkg::TestW'(1);
              axis_q  <= 2'd0;
              hi_q    <= 1'b0;
              state_q <= StBrd;
            end
          end else begin
            // back from the left subtree: counts re-read for this node
            state_q <= StLeaf;
          end
        end
        StBrd:   state_q <= StBdiff;
        StBdiff: state_q <= StMulLo;
        StMulLo: state_q <= StMulHi;
        StMulHi: state_q <= StSign;
        StSign:  state_q <= StMm;
        StMm: begin
          if (hi_q) begin
            state_q <= StNf;
          end else begin
            state_q <= StBrd;
            if (axis_q == 2'd2) begin
              axis_q <= 2'd0;
              hi_q   <= 1'b1;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        StNf: begin
          if (axis_q == 2'd2) begin
            state_q <= StDecide;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= StBrd;
          end
        end
        StDecide: begin
          // reject when the box lies behind the start or the slabs do not overlap
          if (far_q < blrc_pkg::TNegOne || near_q > far_q) begin
            state_q <= StPop;
          end else begin
            state_q <= StLeaf;
          end
        end
        StLeaf: begin
          if (cnt_rd_q != 16'd0) begin
            if (nrec_q >= blrc_pkg::RecW'(blrc_pkg::MaxLeafResults)) begin
              ovf_q   <= 1'b1;
              state_q <= StFinish;
            end else begin
              // previous record goes out now that a later one exists
              res_valid_q           <= pend_valid_q;
              res_q                 <= {pend_q.hit_first_prim, pend_q.hit_count,
                                        pend_q.total_prims, 2'b00};
              pend_valid_q          <= 1'b1;
              pend_q.hit_first_prim <= link_rd_q;
              pend_q.hit_count      <= cnt_rd_q;
              pend_q.total_prims    <= pend_valid_q ?
                  (total_sum[24] ? blrc_pkg::TotalMax : total_sum[23:0]) : 24'(cnt_rd_q);
              pend_q.last_hit       <= 1'b0;
              pend_q.overflow       <= 1'b0;
              nrec_q                <= nrec_q + blrc_pkg::RecW'(1);
              state_q               <= StPop;
            end
          end else if (depth_q >= blrc_pkg::DepthW'(blrc_pkg::StackDepth)) begin
            ovf_q   <= 1'b1;
            state_q <= StFinish;
          end else begin
            cur_node_q  <= child_node;
            cur_child_q <= 2'd0;
            depth_q     <= depth_q + blrc_pkg::DepthW'(1);
            state_q     <= StWalk;
          end
        end
        StPop: begin
          depth_q <= depth_m1;
          state_q <= (depth_m1 == '0) ? StWalk : StPopRd;
        end
        StPopRd: begin
          cur_node_q  <= stk_rd_q[NW+1:2];
          cur_child_q <= stk_rd_q[1:0];
          state_q     <= StWalk;
        end
        StFinish: begin
          res_valid_q  <= 1'b1;
          res_q        <= pend_valid_q ?
              {pend_q.hit_first_prim, pend_q.hit_count, pend_q.total_prims, 1'b1, ovf_q} :
              {56'd0, 1'b1, ovf_q};
          depth_q      <= '0;
          pend_valid_q <= 1'b0;
          state_q      <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  a_last_then_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_hit |=> !res_valid_o)
    else $error("word strobed right after the closing word");

  a_mid_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_hit |-> !res_o.overflow && busy_o)
    else $error("non-final word carries overflow or query already closed");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.req_type == blrc_pkg::ReqQuery |=> busy_o)
    else $error("query taken but block not busy");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= blrc_pkg::DepthW'(blrc_pkg::StackDepth))
    else $error("walk depth beyond stack");

endmodule

>>> sim/blrc_leaf_checker.sv
// checker for the ray leaf collector: mirrors the node table, predicts leaf records and compares
`timescale 1ns / 1ps

module blrc_leaf_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  blrc_pkg::blrc_req_t req_i,
  input  logic                res_valid_o,
  input  blrc_pkg::blrc_res_t res_o,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [31:0]         box_mem [blrc_pkg::NodeCount][6];
  logic [15:0]         count_mem [blrc_pkg::NodeCount];
  logic [15:0]         link_mem [blrc_pkg::NodeCount];
  int                  walk_node [blrc_pkg::StackDepth];
  int                  walk_child [blrc_pkg::StackDepth];
  blrc_pkg::blrc_res_t leaf_records_q [$];

  assign pending_o = leaf_records_q.size();

  function automatic longint recip_dir(logic signed [31:0] d);
    longint dl, u, q;
    dl = longint'(d);
    u  = (dl < 0) ? -dl : dl;
    if (u == 0) return 64'sh1_0000_0000;
    q = 64'sh1_0000_0000 / u;
    return (dl < 0) ? -q : q;
  endfunction

  function automatic longint slab_dist(longint diff, longint inv);
    logic [65:0] prod;
    logic [63:0] md, mi;
    bit          neg;
    neg  = (diff < 0) != (inv < 0);
    md   = (diff < 0) ? -diff : diff;
    mi   = (inv < 0) ? -inv : inv;
    prod = ({2'b0, md} * {2'b0, mi}) >> 16;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic bit box_hit(int n, longint org [3], longint inv [3]);
    longint near_t, far_t, t0, t1, mn, mx;
    near_t = longint'(64'h8000_0000_0000_0000);
    far_t  = longint'(64'h7fff_ffff_ffff_ffff);
    for (int a = 0; a < 3; a++) begin
      t0 = slab_dist(longint'(signed'(box_mem[n][a])) - org[a], inv[a]);
      t1 = slab_dist(longint'(signed'(box_mem[n][a+3])) - org[a], inv[a]);
      mn = (t0 < t1) ? t0 : t1;
      mx = (t0 < t1) ? t1 : t0;
      if (mn > near_t) near_t = mn;
      if (mx < far_t) far_t = mx;
    end
    return !(far_t < longint'(blrc_pkg::TNegOne) || near_t > far_t);
  endfunction

  // depth-first walk, queues one record per hit leaf, or a single empty closing record when no leaf is hit
  function automatic void trace_ray(blrc_pkg::blrc_req_t q);
    longint              org [3], inv [3];
    int                  depth, top, n, nrec, tests;
    int                  total;
    bit                  ovf;
    blrc_pkg::blrc_res_t rec;
    org[0] = longint'(q.ray_origin_x); inv[0] = recip_dir(q.ray_dir_x);
    org[1] = longint'(q.ray_origin_y); inv[1] = recip_dir(q.ray_dir_y);
    org[2] = longint'(q.ray_origin_z); inv[2] = recip_dir(q.ray_dir_z);
    nrec = 0; tests = 0; total = 0; ovf = 0;
    depth = 1; walk_node[0] = 0; walk_child[0] = 0;
    while (depth > 0) begin
      top = depth - 1;
      n   = walk_node[top];
      if (walk_child[top] >= 2) begin
        depth--;
        continue;
      end
      if (walk_child[top] == 0) begin
        if (tests >= blrc_pkg::NodeCount) begin
          ovf = 1;
          break;
        end
        tests++;
        if (!box_hit(n, org, inv)) begin
          depth--;
          continue;
        end
      end
      if (count_mem[n] != 0) begin
        if (nrec >= blrc_pkg::MaxLeafResults) begin
          ovf = 1;
          break;
        end
        total += count_mem[n];
        if (total > int'(blrc_pkg::TotalMax)) total = int'(blrc_pkg::TotalMax);
        rec = '0;
        rec.hit_first_prim = link_mem[n];
        rec.hit_count      = count_mem[n];
        rec.total_prims    = total[23:0];
        leaf_records_q.push_back(rec);
        nrec++;
        depth--;
        continue;
      end
      if (depth >= blrc_pkg::StackDepth) begin
        ovf = 1;
        break;
      end
      walk_node[depth]  = walk_child[top] ? (int'(link_mem[n]) % blrc_pkg::NodeCount)
                                          : ((n + 1) % blrc_pkg::NodeCount);
      walk_child[top]++;
      walk_child[depth] = 0;
      depth++;
    end
    if (nrec == 0) begin
      leaf_records_q.push_back('0);
    end
    rec = leaf_records_q.pop_back();
    rec.last_hit = 1'b1;
    rec.overflow = ovf;
    leaf_records_q.push_back(rec);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blrc_pkg::blrc_res_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (start_i && !busy_o) begin
        if (req_i.req_type == blrc_pkg::ReqWrite) begin
          if (req_i.word_select == blrc_pkg::WordCount)
            count_mem[req_i.node_index] = req_i.word_value[15:0];
          else if (req_i.word_select == blrc_pkg::WordLink)
            link_mem[req_i.node_index] = req_i.word_value[15:0];
          else
            box_mem[req_i.node_index][req_i.word_select] = req_i.word_value;
        end else begin
          trace_ray(req_i);
        end
      end
      if (res_valid_o) begin
        if (leaf_records_q.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual %p", $realtime, res_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = leaf_records_q.pop_front();
          if (res_o.hit_first_prim !== want.hit_first_prim ||
              res_o.hit_count !== want.hit_count ||
              res_o.total_prims !== want.total_prims ||
              res_o.last_hit !== want.last_hit ||
              res_o.overflow !== want.overflow) begin
            $display("%0t: record mismatch, expected %p, actual %p", $realtime, want, res_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb.sv
// testbench top for the ray leaf collector: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb;

  localparam int WatchLimit = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  blrc_pkg::blrc_req_t req_i;
  logic                res_valid_o;
  blrc_pkg::blrc_res_t res_o;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles = 0;
  bit                  no_gaps;
  int                  random_items;

  bvh_ray_leaf_collector_unit i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .res_valid_o, .res_o
  );

  blrc_leaf_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .res_valid_o, .res_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: cycles with no word taken and no record out
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random filler for every request field
  function automatic blrc_pkg::blrc_req_t rand_req();
    logic [255:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return r[$bits(blrc_pkg::blrc_req_t)-1:0];
  endfunction

  // present one word and hold it until taken, then maybe idle
  task automatic send_word(blrc_pkg::blrc_req_t w);
    int gap;
    start_i <= 1'b1;
    req_i   <= w;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      req_i   <= rand_req();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_word(int node, logic [2:0] sel, logic [31:0] val);
    blrc_pkg::blrc_req_t w;
    w = rand_req();
    w.req_type    = blrc_pkg::ReqWrite;
    w.node_index  = node[9:0];
    w.word_select = sel;
    w.word_value  = val;
    send_word(w);
    random_items++;
  endtask

  // all eight words of one node; count and link carry junk in the upper half
  task automatic load_node(int node, logic [31:0] lo [3], logic [31:0] hi [3],
                           logic [15:0] cnt, logic [15:0] link);
    for (int a = 0; a < 3; a++) begin
      write_word(node, 3'(a), lo[a]);
      write_word(node, 3'(a + 3), hi[a]);
    end
    write_word(node, blrc_pkg::WordCount, {16'($urandom), cnt});
    write_word(node, blrc_pkg::WordLink, {16'($urandom), link});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return $urandom;
      2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3:       return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
      default: return 32'($signed($urandom_range(1, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  task automatic rand_box(output logic [31:0] lo [3], output logic [31:0] hi [3]);
    bit wide;
    wide = ($urandom_range(0, 2) == 0);
    for (int a = 0; a < 3; a++) begin
      lo[a] = wide ? 32'h8000_0000 : rand_coord();
      hi[a] = wide ? 32'h7fff_ffff : rand_coord();
    end
  endtask

  task automatic query_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    blrc_pkg::blrc_req_t w;
    w = rand_req();
    w.req_type     = blrc_pkg::ReqQuery;
    w.ray_origin_x = ox;
    w.ray_origin_y = oy;
    w.ray_origin_z = oz;
    w.ray_dir_x    = dx;
    w.ray_dir_y    = dy;
    w.ray_dir_z    = dz;
    send_word(w);
    random_items++;
  endtask

  task automatic rand_query();
    query_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir());
  endtask

  // preorder subtree at next_node, returns through next_node the first free entry
  task automatic build_tree(inout int next_node, input int lvl, input int max_lvl,
                            input bit full_hit);
    logic [31:0] lo [3], hi [3];
    int          me, right;
    me = next_node;
    next_node++;
    if (full_hit) begin
      lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      hi = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    end else begin
      rand_box(lo, hi);
    end
    if (lvl >= max_lvl || (!full_hit && $urandom_range(0, 2) == 0)) begin
      load_node(me, lo, hi, ($urandom_range(0, 7) == 0) ? 16'hffff
                                                         : 16'($urandom_range(1, 300)),
                16'($urandom));
    end else begin
      build_tree(next_node, lvl + 1, max_lvl, full_hit);
      right = next_node;
      build_tree(next_node, lvl + 1, max_lvl, full_hit);
      load_node(me, lo, hi, 16'h0, 16'(right));
    end
  endtask

  initial begin
    logic [31:0] lo [3], hi [3], mlo [3], mhi [3];
    int          nxt;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    no_gaps      = 1'b0;
    random_items = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // boxes every ray hits, and a box far off in the negative corner that rays miss
    lo  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    hi  = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    mlo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    mhi = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};

    // shared subgraph: both children of each node are the next node, test budget runs out
    for (int n = 0; n < 11; n++) load_node(n, lo, hi, 16'h0, 16'(n + 1));
    load_node(11, mlo, mhi, 16'd1, 16'd0);
    query_ray(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0);

    // right child links back to the root, one level deeper each round until the stack is full
    load_node(0, lo, hi, 16'h0, 16'h0);
    load_node(1, mlo, mhi, 16'd4, 16'd0);
    query_ray(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);

    // shared subgraph ending in a leaf: more hit leaves than the result cap
    for (int n = 0; n < 7; n++) load_node(n, lo, hi, 16'h0, 16'(n + 1));
    load_node(7, lo, hi, 16'd5, 16'd77);
    query_ray(32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h8000_0000, 32'h7fff_ffff, 32'h1);
    // cap reached exactly with one level less
    load_node(6, lo, hi, 16'hffff, 16'd3);
    query_ray(32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h1, 32'h0);

    // root that no ray reaches from far behind
    mlo = '{32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000};
    load_node(0, mlo, hi, 16'd3, 16'd9);
    query_ray(32'h0, 32'h0, 32'h0, 32'hffff_0000, 32'hffff_0000, 32'hffff_0000);

    // random scenes: a fresh small tree then several rays through it
    while (random_items < 320) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      nxt = 0;
      build_tree(nxt, 0, $urandom_range(1, 3), ($urandom_range(0, 5) == 0));
      if ($urandom_range(0, 3) == 0) begin
        // node outside the tree, never reached by the walk
        rand_box(lo, hi);
        load_node($urandom_range(16, blrc_pkg::NodeCount - 1), lo, hi,
                  16'($urandom), 16'($urandom));
      end
      repeat ($urandom_range(3, 8)) rand_query();
    end

    @(posedge clk_i);
    start_i <= 1'b0;
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
